/* src/rfclm_pkg.sv */
// Package for the learning remote-code table: frame constants, result codes,
// the search token that walks the cell chain and the table write bundle.
// No dependencies.
`default_nettype none

package rfclm_pkg;

  localparam logic [7:0] FRAME_HEAD = 8'hFD;
  localparam logic [7:0] FRAME_TAIL = 8'hDF;

  // The window keeps the last five bytes; the sixth frame byte is the one arriving.
  localparam int unsigned WIN_KEEP = 5;
  localparam int unsigned FILL_W   = 3;

  // Slot index width covers the largest table (256 entries).
  localparam int unsigned IDX_W = 8;
  localparam int unsigned KEY_W = 24;

  typedef enum logic [2:0] {
    ST_LEARNED   = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_MATCHED   = 3'd3,
    ST_UNKNOWN   = 3'd4,
    ST_ZERO_KEY  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] k;
    logic [7:0] o;
  } frame_t;

  // Search token: one key moving down the chain, gathering what the cells saw.
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic             found;
    logic [IDX_W-1:0] found_idx;
    logic             empty;
    logic [IDX_W-1:0] empty_idx;
  } tok_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
  } wr_t;

endpackage

`default_nettype wire

/* src/rf_code_learn_and_match_core.sv */
// Top level of the learning remote-code table: receive window, chain of table
// cells, control and output register. Depends on rfclm_pkg, rfclm_window, rfclm_cell.
//
//   channel   direction  beat contents (low bit first)
//   s_axis    in         tdata: rx_byte[7:0]
//   m_axis    out        tdata: status[2:0] code_a code_b code_k code_o slot[3:0] pad
//   cfg       in         cfg_we_i writes cfg_wdata_i into learn_q
//
// A byte that does not close a frame only shifts into the window. A closing byte sends
// the key down the cell chain, one cell per cycle; no byte is taken until the result
// made from the token leaving the last cell has been loaded into the output register.
// Reset clears the window, the mode and every table cell at once.
// Input bytes are taken while an earlier result waits in the output register.
`default_nettype none

module rf_code_learn_and_match_core #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], code_a[10:3], code_b[18:11], code_k[26:19], code_o[34:27],
  // slot[38:35], zero[39]
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);
  import rfclm_pkg::*;

  state_e      state_q, state_d;
  logic        learn_q;
  logic        in_acc;
  logic        hit;
  frame_t      frame_in;
  frame_t      frm_q;
  tok_t        tok_head;
  tok_t        tok [TABLE_ENTRIES+1];
  tok_t        res_q;
  wr_t         wr;
  logic        out_free;
  logic        load_out;
  logic        cap_res;
  logic        zero_key;
  status_e     status;
  logic [3:0]  slot;
  logic        m_valid_q;
  logic [39:0] m_data_q;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  rfclm_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_acc),
    .byte_i  (s_axis_tdata),
    .hit_o   (hit),
    .frame_o (frame_in)
  );

  // Token injected at the head of the chain.
  always_comb begin
    tok_head           = '0;
    tok_head.valid     = in_acc && hit;
    tok_head.key       = {frame_in.a, frame_in.b, frame_in.k};
  end

  assign tok[0] = tok_head;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    rfclm_cell #(
      .CellIdx (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1]),
      .wr_i   (wr)
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc && hit) state_d = S_SCAN;
      S_SCAN:   if (tok[TABLE_ENTRIES].valid) state_d = S_RESULT;
      S_RESULT: if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    cap_res       = (state_q == S_SCAN) && tok[TABLE_ENTRIES].valid;
    load_out      = (state_q == S_RESULT) && out_free;
  end

  // Result decision from the token that left the end of the chain.
  always_comb begin
    zero_key = (res_q.key == '0);
    status   = ST_ZERO_KEY;
    slot     = 4'd0;
    wr.en    = 1'b0;
    wr.idx   = res_q.empty_idx;
    wr.key   = res_q.key;
    if (!zero_key) begin
      if (learn_q) begin
        if (res_q.found) begin
          status = ST_DUPLICATE;
          slot   = res_q.found_idx[3:0];
        end else if (res_q.empty) begin
          status = ST_LEARNED;
          slot   = res_q.empty_idx[3:0];
          wr.en  = load_out;
        end else begin
          status = ST_FULL;
        end
      end else if (res_q.found) begin
        status = ST_MATCHED;
        slot   = res_q.found_idx[3:0];
      end else begin
        status = ST_UNKNOWN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      learn_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        learn_q <= cfg_wdata_i;
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && hit) begin
      frm_q <= frame_in;
    end
    if (cap_res) begin
      res_q <= tok[TABLE_ENTRIES];
    end
    if (load_out) begin
      m_data_q <= {1'b0, slot, frm_q.o, frm_q.k, frm_q.b, frm_q.a, status};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

/* src/rfclm_window.sv */
// Receive window: keeps the last five bytes and flags a frame when the
// arriving byte closes one. Depends on rfclm_pkg.
`default_nettype none

module rfclm_window (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic [7:0]      byte_i,
  output logic            hit_o,
  output rfclm_pkg::frame_t frame_o
);
  import rfclm_pkg::*;

  logic [7:0]        win_q [WIN_KEEP];
  logic [FILL_W-1:0] fill_q;
  logic [FILL_W-1:0] fill_d;

  // The oldest kept byte becomes the head once the new byte shifts in.
  assign hit_o = (fill_q == FILL_W'(WIN_KEEP)) && (win_q[0] == FRAME_HEAD) &&
                 (byte_i == FRAME_TAIL);

  assign frame_o.a = win_q[1];
  assign frame_o.b = win_q[2];
  assign frame_o.k = win_q[3];
  assign frame_o.o = win_q[4];

  always_comb begin
    fill_d = fill_q;
    if (push_i) begin
      if (hit_o) begin
        fill_d = '0;
      end else if (fill_q != FILL_W'(WIN_KEEP)) begin
        fill_d = fill_q + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      for (int j = 0; j < WIN_KEEP; j++) begin
        win_q[j] <= '0;
      end
    end else if (push_i) begin
      fill_q <= fill_d;
      if (hit_o) begin
        for (int j = 0; j < WIN_KEEP; j++) begin
          win_q[j] <= '0;
        end
      end else begin
        for (int j = 0; j < WIN_KEEP - 1; j++) begin
          win_q[j] <= win_q[j+1];
        end
        win_q[WIN_KEEP-1] <= byte_i;
      end
    end
  end

endmodule

`default_nettype wire

/* src/rfclm_cell.sv */
// One table cell: holds a single learned key, compares it with the passing
// search token and hands the updated token on. Depends on rfclm_pkg.
`default_nettype none

module rfclm_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rfclm_pkg::tok_t tok_i,
  output rfclm_pkg::tok_t tok_o,
  input  rfclm_pkg::wr_t  wr_i
);
  import rfclm_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CellIdx);

  logic [KEY_W-1:0] entry_q;
  logic             key_hit;
  logic             is_empty;
  tok_t             tok_d;
  tok_t             tok_q;

  assign key_hit  = (entry_q == tok_i.key);
  assign is_empty = (entry_q == '0);

  // The first hit along the chain wins, matching a lowest-index search.
  always_comb begin
    tok_d           = tok_i;
    tok_d.found     = tok_i.found | key_hit;
    tok_d.found_idx = tok_i.found ? tok_i.found_idx : MyIdx;
    tok_d.empty     = tok_i.empty | is_empty;
    tok_d.empty_idx = tok_i.empty ? tok_i.empty_idx : MyIdx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (wr_i.en && (wr_i.idx == MyIdx)) begin
      entry_q <= wr_i.key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

/* src/rfclm_checker.sv */
// Port-level checks for the learning remote-code table and the bind that
// attaches them to the top level. Depends on rfclm_pkg.
`default_nettype none

module rfclm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  import rfclm_pkg::*;

  logic [2:0] st;
  logic [3:0] sl;

  assign st = m_axis_tdata[2:0];
  assign sl = m_axis_tdata[38:35];

  // A stalled result beat holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Only defined result codes are produced.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (st <= ST_ZERO_KEY))
    else $error("undefined status code");

  // The reserved code is given exactly for the all-zero key.
  a_zero_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[26:3] == '0) == (st == ST_ZERO_KEY)))
    else $error("zero key status mismatch");

  // Results that name no slot report slot zero.
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st == ST_FULL || st == ST_UNKNOWN || st == ST_ZERO_KEY)
      |-> (sl == 4'd0))
    else $error("slot set on a result without a slot");

endmodule

bind rf_code_learn_and_match_core rfclm_checker u_rfclm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* test/rfclm_result_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the learning remote-code table. It follows the byte stream and the
// mode register, predicts every frame result and compares it with the output beats.
// Depends on rfclm_pkg.
module rfclm_result_checker #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  input  logic        rx_ready_i,
  input  logic [7:0]  rx_data_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [39:0] res_data_i,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  output int          mismatch_cnt_o,
  output int          pending_o
);
  import rfclm_pkg::*;

  typedef struct packed {
    status_e    status;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] k;
    logic [7:0] o;
    logic [3:0] slot;
  } frame_result_t;

  logic [7:0]    rx_window [6];
  int            window_fill;
  logic [23:0]   code_tbl [ENTRIES];
  logic          learn_mode;
  frame_result_t frame_result_q [$];
  int            mismatches = 0;

  function automatic void clear_window();
    for (int i = 0; i < 6; i++) rx_window[i] = '0;
    window_fill = 0;
  endfunction

  // Shifts one byte into the window and, when it closes a frame, works out the
  // status and slot the table walk must produce.
  function automatic bit take_rx_byte(input logic [7:0] rx, output frame_result_t res);
    logic [23:0] key;
    int          hit;
    int          hole;
    res = '0;
    for (int i = 0; i < 5; i++) rx_window[i] = rx_window[i + 1];
    rx_window[5] = rx;
    if (window_fill < 6) window_fill++;
    if (window_fill < 6 || rx_window[0] != FRAME_HEAD || rx_window[5] != FRAME_TAIL) begin
      return 1'b0;
    end
    key = {rx_window[1], rx_window[2], rx_window[3]};
    res.a = rx_window[1];
    res.b = rx_window[2];
    res.k = rx_window[3];
    res.o = rx_window[4];
    clear_window();
    // Walk downward so the lowest matching and lowest empty slots win.
    hit = -1;
    hole = -1;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (code_tbl[i] == key) hit = i;
      if (code_tbl[i] == '0) hole = i;
    end
    if (key == '0) begin
      res.status = ST_ZERO_KEY;
    end else if (learn_mode) begin
      if (hit >= 0) begin
        res.status = ST_DUPLICATE;
        res.slot = hit[3:0];
      end else if (hole >= 0) begin
        code_tbl[hole] = key;
        res.status = ST_LEARNED;
        res.slot = hole[3:0];
      end else begin
        res.status = ST_FULL;
      end
    end else if (hit >= 0) begin
      res.status = ST_MATCHED;
      res.slot = hit[3:0];
    end else begin
      res.status = ST_UNKNOWN;
    end
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string what, input frame_result_t want,
                               input logic [39:0] data);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected status=%0d a=%h b=%h k=%h o=%h slot=%0d, got tdata=%h",
               $time, what, want.status, want.a, want.b, want.k, want.o, want.slot, data);
    end
  endtask

  always @(posedge clk_i) begin : watch
    frame_result_t want;
    frame_result_t got;
    if (!rst_ni) begin
      clear_window();
      for (int i = 0; i < ENTRIES; i++) code_tbl[i] = '0;
      learn_mode = 1'b0;
      frame_result_q.delete();
    end else begin
      if (cfg_we_i) learn_mode = cfg_wdata_i;
      if (rx_valid_i && rx_ready_i) begin
        if (take_rx_byte(rx_data_i, want)) frame_result_q.push_back(want);
      end
      if (res_valid_i && res_ready_i) begin
        got.status = status_e'(res_data_i[2:0]);
        got.a = res_data_i[10:3];
        got.b = res_data_i[18:11];
        got.k = res_data_i[26:19];
        got.o = res_data_i[34:27];
        got.slot = res_data_i[38:35];
        if (frame_result_q.size() == 0) begin
          note_mismatch("result beat with no frame pending", '0, res_data_i);
        end else begin
          want = frame_result_q.pop_front();
          if (got !== want || res_data_i[39] !== 1'b0) begin
            note_mismatch("result beat differs", want, res_data_i);
          end
        end
      end
    end
    pending_o <= frame_result_q.size();
    mismatch_cnt_o <= mismatches;
  end

endmodule

/* test/tb_rf_code_learn_and_match_core.sv */
`timescale 1ns / 100ps
// Testbench top for rf_code_learn_and_match_core: drives received bytes, the mode
// register and output back-pressure, and gives the verdict from the checker's counts.
// Depends on rfclm_pkg, rf_code_learn_and_match_core and rfclm_result_checker.
module tb_rf_code_learn_and_match_core;
  import rfclm_pkg::*;

  localparam int unsigned TBL_N = 16;
  localparam int LAT = TBL_N + 4;
  localparam int RX_HOLD = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES = 8;
  localparam int PHASE_BYTES = 135;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tready = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [39:0] m_axis_tdata;
  int          mismatch_cnt;
  int          pending_cnt;
  int          idle_pct = 30;
  int          hold_reqs = 0;
  logic [23:0] key_pool [$];

  rf_code_learn_and_match_core #(
    .TABLE_ENTRIES(TBL_N)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  rfclm_result_checker #(
    .ENTRIES(TBL_N)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_valid_i    (s_axis_tvalid),
    .rx_ready_i    (s_axis_tready),
    .rx_data_i     (s_axis_tdata),
    .res_valid_i   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_data_i    (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (pending_cnt)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin : result_sink
    int hold_left;
    int holds_done;
    hold_left = 0;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != holds_done) begin
        holds_done = hold_reqs;
        hold_left = RX_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_rf_code_learn_and_match_core: FAIL");
    $finish;
  end

  // Returns at the edge where the beat was taken; tvalid stays high afterwards until the
  // caller or an idle spell in the next call lowers it.
  task automatic send_byte(input logic [7:0] rx);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= rx;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_frame(input logic [23:0] key, input logic [7:0] tail_byte);
    send_byte(FRAME_HEAD);
    send_byte(key[23:16]);
    send_byte(key[15:8]);
    send_byte(key[7:0]);
    send_byte(tail_byte);
    send_byte(FRAME_TAIL);
  endtask

  // Stops sending until every pending frame has produced its result beat.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (LAT) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic learn);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= learn;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Reuses a key already sent in nearly half the picks, so duplicates and matches are frequent.
  function automatic logic [23:0] pick_key();
    int          r;
    logic [23:0] key;
    r = $urandom_range(99);
    if (r < 3) return '0;
    if (r < 50 && key_pool.size() > 0) return key_pool[$urandom_range(key_pool.size() - 1)];
    key = 24'($urandom());
    key_pool.push_back(key);
    if (key_pool.size() > 48) void'(key_pool.pop_front());
    return key;
  endfunction

  initial begin : stimulus
    int frame_bytes;
    int r;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Five bytes are too few for a frame; the sixth closes one with the zero key.
    send_byte(FRAME_HEAD);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(FRAME_TAIL);
    send_byte(FRAME_TAIL);
    wait_drained();
    write_mode(1'b1);
    send_frame(24'hFFFFFF, 8'h00);
    send_frame(24'hFFFFFF, 8'h7F);
    wait_drained();
    write_mode(1'b0);
    send_frame(24'hFFFFFF, 8'h01);
    key_pool.push_back(24'hFFFFFF);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_mode(p % 3 != 1);
      idle_pct = (p == 3) ? 0 : 30;
      if (p == 5) hold_reqs++;
      frame_bytes = 0;
      while (frame_bytes < PHASE_BYTES) begin
        r = $urandom_range(99);
        if (r < 70 || p == 5) begin
          send_frame(pick_key(), 8'($urandom_range(255)));
          frame_bytes += 6;
        end else if (r < 85) begin
          // A frame head cut short.
          send_byte(FRAME_HEAD);
          repeat ($urandom_range(4)) send_byte(8'($urandom_range(255)));
        end else begin
          repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
        end
      end
    end
    wait_drained();

    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("tb_rf_code_learn_and_match_core: PASS");
    end else begin
      $display("tb_rf_code_learn_and_match_core: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/rfclm_pkg.sv
src/rfclm_window.sv
src/rfclm_cell.sv
src/rf_code_learn_and_match_core.sv
src/rfclm_checker.sv
test/rfclm_result_checker.sv
test/tb_rf_code_learn_and_match_core.sv
